### rtl/core/io_expander_i2c_pin_writer_top_macros.svh
// Assertion macros for the I2C pin writer top level.
// Used only by io_expander_i2c_pin_writer_top.sv; needs i_clk and i_rst_n in scope.
`ifndef IO_EXPANDER_I2C_PIN_WRITER_TOP_MACROS_SVH
`define IO_EXPANDER_I2C_PIN_WRITER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define IOX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IOX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ioexp_pkg.sv
// Shared types and constants for the I2C pin writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ioexp_pkg;

    localparam int unsigned NUM_PINS   = 24;
    localparam int unsigned NUM_PHASES = 60;
    localparam int unsigned Q_DEPTH    = 2;

    localparam logic [15:0] CMD_BIDIR = 16'h6000;
    localparam logic [15:0] CMD_OC_LO = 16'h4400;
    localparam logic [15:0] CMD_OC_HI = 16'h4600;
    localparam logic [7:0]  MSB_MASK  = 8'h80;

    // bit slot holding the acknowledge clock
    localparam logic [3:0] ACK_SLOT  = 4'd8;
    localparam logic [1:0] LAST_SUB  = 2'd2;

    // one queued write transaction
    typedef struct packed {
        logic [15:0]         word;    // command byte, data byte
        logic [NUM_PINS-1:0] shadow;  // shadow after the update
    } t_job;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_q_stat;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_START,
        SEG_CMD,
        SEG_DATA,
        SEG_STOP
    } t_seg;

endpackage

`default_nettype wire

### rtl/core/io_expander_i2c_pin_writer_top.sv
// I2C pin writer: writes one expander pin per transaction as a bit-banged bus write.
// Depends on ioexp_pkg, ioexp_front, ioexp_queue, ioexp_back and the macros header.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transaction carries a pin index
//    and a level. The pin is updated in a 24-bit shadow at acceptance; indexes
//    24..31 leave the shadow alone but still produce a bus write (high bank).
//  - Output channel (o_out_valid / i_out_stall): 60 transactions per input, one
//    per bus phase: start (3), command byte (27), data byte (27), stop (3).
//    o_last marks the final stop phase; o_pin_shadow is the post-update shadow.
//  - Path to first phase: queue entry, sequencer start, then the output register.
//  - Rate: the phase sequencer emits one phase per cycle unless the receiver
//    stalls; consecutive writes run with no gap between them.
//  - A 2-deep job queue lets up to two further inputs be taken while a write
//    is still going out; o_in_stall rises only when that queue is full.
//  - When the receiver stalls, the current phase holds in the output register
//    and the sequencer freezes; inputs keep filling the queue.
//  - Reset (synchronous, active low) clears the shadow, empties the queue and
//    returns the sequencer to idle with no output valid.
`default_nettype none

`include "io_expander_i2c_pin_writer_top_macros.svh"

module io_expander_i2c_pin_writer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [4:0]  i_pin_index,
    input  wire logic        i_pin_level,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_scl,
    output logic             o_sda,
    output logic             o_last,
    output logic [23:0]      o_pin_shadow
);
    import ioexp_pkg::*;

    t_q_stat q_stat;
    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;

    // front: shadow update and command/data word build
    ioexp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_pin_index (i_pin_index),
        .i_pin_level (i_pin_level),
        .i_q_stat    (q_stat),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    // decouples input acceptance from the bus sequence
    ioexp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // back: 60-phase bus sequencer with registered output
    ioexp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_q_stat     (q_stat),
        .i_out_stall  (i_out_stall),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_scl        (o_scl),
        .o_sda        (o_sda),
        .o_last       (o_last),
        .o_pin_shadow (o_pin_shadow)
    );

    // stop condition ends with both lines released
    `IOX_ASSERT_NOW(a_last_released, o_out_valid && o_last, o_scl && o_sda, "last phase not released")
    // sequencer never pops an empty queue
    `IOX_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
    // occupancy stays within the queue depth
    `IOX_ASSERT_NEXT(a_count_bound, push || pop, q_stat.count <= 2'(Q_DEPTH), "queue overflow")

endmodule

`default_nettype wire

### rtl/core/ioexp_front.sv
// Front end: accepts pin updates, keeps the shadow, builds command/data words.
// Depends on ioexp_pkg.
`default_nettype none

module ioexp_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [4:0]               i_pin_index,
    input  wire logic                     i_pin_level,
    input  wire ioexp_pkg::t_q_stat       i_q_stat,
    output logic                          o_in_stall,
    output logic                          o_push,
    output ioexp_pkg::t_job               o_job
);
    import ioexp_pkg::*;

    logic [NUM_PINS-1:0] r_shadow;
    logic [NUM_PINS-1:0] n_shadow;

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        n_shadow = r_shadow;
        if (i_pin_index inside {[5'd0:5'd23]}) begin
            n_shadow[i_pin_index] = i_pin_level;
        end
    end

    always_comb begin
        o_job.shadow = n_shadow;
        if (i_pin_index inside {[5'd0:5'd7]}) begin
            o_job.word = CMD_BIDIR | {8'd0, n_shadow[7:0]};
        end else if (i_pin_index inside {[5'd8:5'd15]}) begin
            o_job.word = CMD_OC_LO | {8'd0, n_shadow[15:8]};
        end else begin
            o_job.word = CMD_OC_HI | {8'd0, n_shadow[23:16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow <= '0;
        end else if (o_push) begin
            r_shadow <= n_shadow;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ioexp_queue.sv
// Two-entry job queue between front end and bus sequencer.
// Depends on ioexp_pkg.
`default_nettype none

module ioexp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ioexp_pkg::t_job     i_job,
    input  wire logic                i_pop,
    output ioexp_pkg::t_job          o_job,
    output ioexp_pkg::t_q_stat       o_stat
);
    import ioexp_pkg::*;

    t_job       r_mem [Q_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == 2'(Q_DEPTH));
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/ioexp_back.sv
// Back end: walks the 60 bus phases of one job into a registered output stage.
// Depends on ioexp_pkg.
`default_nettype none

module ioexp_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ioexp_pkg::t_job       i_job,
    input  wire ioexp_pkg::t_q_stat    i_q_stat,
    input  wire logic                  i_out_stall,
    output logic                       o_pop,
    output logic                       o_out_valid,
    output logic                       o_scl,
    output logic                       o_sda,
    output logic                       o_last,
    output logic [23:0]                o_pin_shadow
);
    import ioexp_pkg::*;

    t_seg       r_seg, n_seg;
    logic [3:0] r_bit, n_bit;
    logic [1:0] r_sub, n_sub;
    t_job       r_job;

    logic        r_out_valid;
    logic        r_scl, r_sda, r_last;
    logic [23:0] r_pin_shadow;

    logic       out_free;
    logic       emit;
    logic       ph_scl, ph_sda, ph_last;
    logic [7:0] cur_byte;
    logic       data_bit;

    assign out_free = !r_out_valid || !i_out_stall;
    assign cur_byte = (r_seg == SEG_CMD) ? r_job.word[15:8] : r_job.word[7:0];
    assign data_bit = |(cur_byte & (MSB_MASK >> r_bit[2:0]));

    always_comb begin
        n_seg   = r_seg;
        n_bit   = r_bit;
        n_sub   = r_sub;
        o_pop   = 1'b0;
        emit    = 1'b0;
        ph_scl  = 1'b0;
        ph_sda  = 1'b1;
        ph_last = 1'b0;
        case (r_seg)
            SEG_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_seg = SEG_START;
                    n_bit = 4'd0;
                    n_sub = 2'd0;
                end
            end
            SEG_START: begin
                emit   = out_free;
                ph_scl = (r_sub != LAST_SUB);
                ph_sda = (r_sub == 2'd0);
                if (emit) begin
                    if (r_sub == LAST_SUB) begin
                        n_sub = 2'd0;
                        n_bit = 4'd0;
                        n_seg = SEG_CMD;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            SEG_CMD, SEG_DATA: begin
                emit   = out_free;
                ph_scl = (r_sub == 2'd1);
                ph_sda = (r_bit == ACK_SLOT) ? 1'b1 : data_bit;
                if (emit) begin
                    if (r_sub == LAST_SUB) begin
                        n_sub = 2'd0;
                        if (r_bit == ACK_SLOT) begin
                            n_bit = 4'd0;
                            n_seg = (r_seg == SEG_CMD) ? SEG_DATA : SEG_STOP;
                        end else begin
                            n_bit = r_bit + 4'd1;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            SEG_STOP: begin
                emit    = out_free;
                ph_scl  = (r_sub != 2'd0);
                ph_sda  = (r_sub == LAST_SUB);
                ph_last = (r_sub == LAST_SUB);
                if (emit) begin
                    if (r_sub == LAST_SUB) begin
                        n_sub = 2'd0;
                        n_bit = 4'd0;
                        // chain straight into the next queued job
                        if (!i_q_stat.empty) begin
                            o_pop = 1'b1;
                            n_seg = SEG_START;
                        end else begin
                            n_seg = SEG_IDLE;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            default: begin
                n_seg = SEG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_IDLE;
            r_bit <= 4'd0;
            r_sub <= 2'd0;
        end else begin
            r_seg <= n_seg;
            r_bit <= n_bit;
            r_sub <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_scl        <= ph_scl;
            r_sda        <= ph_sda;
            r_last       <= ph_last;
            r_pin_shadow <= r_job.shadow;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl        = r_scl;
    assign o_sda        = r_sda;
    assign o_last       = r_last;
    assign o_pin_shadow = r_pin_shadow;

endmodule

`default_nettype wire
